/* sv/cgpc_pkg.sv */
// Shared types, constants and CRC15 table functions for the cell-group PEC checker.
// No dependencies; every other file in this folder imports it.
`default_nettype none
package cgpc_pkg;

  localparam int MAX_GROUPS = 4;

  localparam logic [15:0] PEC_SEED = 16'h0010;
  localparam logic [15:0] CRC_GEN  = 16'h4599;

  // Byte positions inside one eight-byte register group
  localparam logic [2:0] POS_FIRST    = 3'd0;
  localparam logic [2:0] POS_PEC_HIGH = 3'd6;
  localparam logic [2:0] POS_PEC_LOW  = 3'd7;
  localparam int         DATA_BYTES   = 6;

  // Queue between front and back
  localparam int MID_DEPTH = 4;
  localparam int MID_PTR_W = $clog2(MID_DEPTH);
  localparam int MID_CNT_W = $clog2(MID_DEPTH + 1);

  // Register map
  localparam logic REG_GROUPS_PER_SWEEP = 1'b0;
  localparam logic [2:0] GROUPS_RESET = 3'd4;

  typedef struct packed {
    logic [7:0] rx_byte;
    logic       restart;
  } item_t;

  typedef struct packed {
    logic [1:0]  group_number;
    logic [15:0] cell_code_first;
    logic [15:0] cell_code_second;
    logic [15:0] cell_code_third;
    logic        pec_ok;
    logic        sweep_failed;
    logic        last_group;
  } result_t;

  // A byte after classification by the front end
  typedef struct packed {
    logic [7:0] rx_byte;
    logic [2:0] pos;
    logic [1:0] group;
    logic       last;
    logic       restart;
  } work_t;

  // Table entry, formed bitwise with 16-bit truncating shifts
  function automatic logic [15:0] crc_entry(input logic [7:0] idx);
    logic [15:0] r;
    r = {1'b0, idx, 7'b0};
    for (int b = 0; b < 8; b++) begin
      if (r[14]) begin
        r = {r[14:0], 1'b0} ^ CRC_GEN;
      end else begin
        r = {r[14:0], 1'b0};
      end
    end
    return r;
  endfunction

  function automatic logic [15:0] crc_step(input logic [15:0] crc, input logic [7:0] v);
    logic [7:0] addr;
    addr = crc[14:7] ^ v;
    return {crc[7:0], 8'h00} ^ crc_entry(addr);
  endfunction

endpackage
`default_nettype wire

/* sv/cgpc_front.sv */
// Front end: tracks byte position and group count, tags each accepted byte.
// Depends on cgpc_pkg.
`default_nettype none
module cgpc_front (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire cgpc_pkg::item_t  item,
  input  wire logic             accept,
  input  wire logic [2:0]       groups_per_sweep,
  output cgpc_pkg::work_t       work
);
  import cgpc_pkg::*;

  logic [2:0] pos;
  logic [1:0] group;
  logic [2:0] pos_eff;
  logic [1:0] group_eff;
  logic [2:0] limit;
  logic [2:0] group_plus;
  logic       last;

  always_comb begin
    pos_eff   = item.restart ? POS_FIRST : pos;
    group_eff = item.restart ? 2'd0 : group;
    if (groups_per_sweep == 3'd0) begin
      limit = 3'd1;
    end else if (groups_per_sweep > 3'(MAX_GROUPS)) begin
      limit = 3'(MAX_GROUPS);
    end else begin
      limit = groups_per_sweep;
    end
    group_plus = {1'b0, group_eff} + 3'd1;
    last       = (group_plus >= limit);
  end

  assign work = '{rx_byte: item.rx_byte, pos: pos_eff, group: group_eff,
                  last: last, restart: item.restart};

  always_ff @(posedge clk) begin
    if (rst) begin
      pos   <= POS_FIRST;
      group <= 2'd0;
    end else if (accept) begin
      pos <= pos_eff + 3'd1;
      if (pos_eff == POS_PEC_LOW) begin
        group <= last ? 2'd0 : group_plus[1:0];
      end else begin
        group <= group_eff;
      end
    end
  end

endmodule
`default_nettype wire

/* sv/cgpc_mid_queue.sv */
// Short first-word-fall-through queue of tagged bytes between front and back.
// Depends on cgpc_pkg.
`default_nettype none
module cgpc_mid_queue (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             wr_en,
  input  wire cgpc_pkg::work_t  wr_data,
  output logic                  full,
  input  wire logic             rd_en,
  output cgpc_pkg::work_t       rd_data,
  output logic                  valid
);
  import cgpc_pkg::*;

  work_t                slots [MID_DEPTH];
  logic [MID_PTR_W-1:0] wr_ptr;
  logic [MID_PTR_W-1:0] rd_ptr;
  logic [MID_CNT_W-1:0] count;

  assign full    = (count == MID_CNT_W'(MID_DEPTH));
  assign valid   = (count != '0);
  assign rd_data = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      slots[wr_ptr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (wr_en) begin
        wr_ptr <= wr_ptr + MID_PTR_W'(1);
      end
      if (rd_en) begin
        rd_ptr <= rd_ptr + MID_PTR_W'(1);
      end
      if (wr_en && !rd_en) begin
        count <= count + MID_CNT_W'(1);
      end else if (rd_en && !wr_en) begin
        count <= count - MID_CNT_W'(1);
      end
    end
  end

endmodule
`default_nettype wire

/* sv/cgpc_back.sv */
// Back end: CRC15 step per data byte, PEC compare, result assembly and a
// two-word result queue. Depends on cgpc_pkg.
`default_nettype none
module cgpc_back (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire cgpc_pkg::work_t  work,
  input  wire logic             work_valid,
  output logic                  take,
  output cgpc_pkg::result_t     result,
  output logic                  empty,
  input  wire logic             pop
);
  import cgpc_pkg::*;

  logic [15:0] crc;
  logic [7:0]  data_bytes [DATA_BYTES];
  logic [7:0]  pec_high_byte;
  logic        sticky_error;

  result_t     out_slots [2];
  logic        out_head;
  logic [1:0]  out_count;

  logic [15:0] crc_base;
  logic [15:0] calc;
  logic [15:0] recv;
  logic        ok;
  logic        sticky_base;
  logic        sticky_now;
  logic        emit;
  logic        popped;
  logic        out_tail;
  result_t     res_new;

  assign take   = work_valid && (out_count != 2'd2);
  assign emit   = take && (work.pos == POS_PEC_LOW);
  assign empty  = (out_count == 2'd0);
  assign popped = pop && !empty;
  assign result = out_slots[out_head];
  assign out_tail = out_head ^ out_count[0];

  always_comb begin
    crc_base    = (work.pos == POS_FIRST) ? PEC_SEED : crc;
    calc        = {crc[14:0], 1'b0};
    recv        = {pec_high_byte, work.rx_byte};
    ok          = (calc == recv);
    sticky_base = work.restart ? 1'b0 : sticky_error;
    sticky_now  = sticky_base | !ok;
    res_new = '{group_number:     work.group,
                cell_code_first:  {data_bytes[1], data_bytes[0]},
                cell_code_second: {data_bytes[3], data_bytes[2]},
                cell_code_third:  {data_bytes[5], data_bytes[4]},
                pec_ok:           ok,
                sweep_failed:     sticky_now,
                last_group:       work.last};
  end

  // Payload stores
  always_ff @(posedge clk) begin
    if (take && (work.pos < POS_PEC_HIGH)) begin
      data_bytes[work.pos] <= work.rx_byte;
    end
    if (take && (work.pos == POS_PEC_HIGH)) begin
      pec_high_byte <= work.rx_byte;
    end
    if (emit) begin
      out_slots[out_tail] <= res_new;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      crc          <= PEC_SEED;
      sticky_error <= 1'b0;
      out_head     <= 1'b0;
      out_count    <= 2'd0;
    end else begin
      if (take) begin
        if (work.pos < POS_PEC_HIGH) begin
          crc <= crc_step(crc_base, work.rx_byte);
        end
        if (emit) begin
          sticky_error <= work.last ? 1'b0 : sticky_now;
        end else begin
          sticky_error <= sticky_base;
        end
      end
      if (popped) begin
        out_head <= !out_head;
      end
      if (emit && !popped) begin
        out_count <= out_count + 2'd1;
      end else if (popped && !emit) begin
        out_count <= out_count - 2'd1;
      end
    end
  end

endmodule
`default_nettype wire

/* sv/cell_group_pec_checker_top.sv */
// Cell-group PEC checker: one received byte per cycle, CRC15 over six data bytes.
// Throughput: one byte accepted every cycle while the result queue keeps moving.
// Result path: the eighth byte of a group is queued between front and back when accepted,
// and its word enters the result queue when the back end takes it (held while that queue is full).
// Reset (rst, synchronous): empties both queues, clears position, group count and
// sticky error, seeds the CRC with 16 and sets groups_per_sweep to 4.
`default_nettype none
module cell_group_pec_checker_top (
  input  wire logic               clk,
  input  wire logic               rst,
  // byte side
  input  wire cgpc_pkg::item_t    item,
  input  wire logic               push,
  output logic                    full,
  // result side
  output cgpc_pkg::result_t       result,
  output logic                    empty,
  input  wire logic               pop,
  // configuration port
  input  wire logic               psel,
  input  wire logic               penable,
  input  wire logic               pwrite,
  input  wire logic [2:0]         paddr,
  input  wire logic [31:0]        pwdata,
  output logic [31:0]             prdata,
  output logic                    pready
);
  import cgpc_pkg::*;

  logic [2:0] groups_per_sweep;
  logic       accept;
  work_t      front_work;
  work_t      mid_work;
  logic       mid_full;
  logic       mid_valid;
  logic       back_take;

  // Configuration: one register, groups_per_sweep, at byte addresses 0 to 3 (paddr[2] low).
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      groups_per_sweep <= GROUPS_RESET;
    end else if (psel && penable && pwrite && (paddr[2] == REG_GROUPS_PER_SWEEP)) begin
      groups_per_sweep <= pwdata[2:0];
    end
  end

  always_comb begin
    prdata = '0;
    if (paddr[2] == REG_GROUPS_PER_SWEEP) begin
      prdata = {29'd0, groups_per_sweep};
    end
  end

  // Accept a byte whenever the queue between front and back has room.
  assign full   = mid_full;
  assign accept = push && !mid_full;

  // Front: tag the byte with its position, group and last-of-sweep mark.
  cgpc_front u_front (
    .clk              (clk),
    .rst              (rst),
    .item             (item),
    .accept           (accept),
    .groups_per_sweep (groups_per_sweep),
    .work             (front_work)
  );

  // Decouple front from back so a stalled result side only backs up the queue.
  cgpc_mid_queue u_mid (
    .clk     (clk),
    .rst     (rst),
    .wr_en   (accept),
    .wr_data (front_work),
    .full    (mid_full),
    .rd_en   (back_take),
    .rd_data (mid_work),
    .valid   (mid_valid)
  );

  // Back: advance the CRC, hold the data bytes, compare on the PEC low byte.
  cgpc_back u_back (
    .clk        (clk),
    .rst        (rst),
    .work       (mid_work),
    .work_valid (mid_valid),
    .take       (back_take),
    .result     (result),
    .empty      (empty),
    .pop        (pop)
  );

  // A failed PEC always shows in the sweep-wide flag of the same word.
  a_fail_sticky: assert property (@(posedge clk) disable iff (rst)
    (!empty && !result.pec_ok) |-> result.sweep_failed)
    else $error("failed group without sweep_failed");

  // The back end taking a PEC low byte must leave a word in the result queue.
  a_emit_word: assert property (@(posedge clk) disable iff (rst)
    (back_take && (mid_work.pos == POS_PEC_LOW)) |=> !empty)
    else $error("group completed but result queue empty");

  // Restart always opens group zero.
  a_restart_group: assert property (@(posedge clk) disable iff (rst)
    (accept && item.restart) |-> (front_work.group == 2'd0 && front_work.pos == POS_FIRST))
    else $error("restart byte not tagged as first byte of group zero");

endmodule
`default_nettype wire

/* tb/sv/testbench.sv */
// Self-checking bench for cell_group_pec_checker_top: byte words in, group results out.
// Depends on cgpc_pkg for the port types and on the RTL of the block; nothing else.
// A local CRC15 group predictor supplies the expected words for the random traffic.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import cgpc_pkg::*;

  localparam int LIMIT_CYCLES = 200000;
  localparam int HOLD_CYCLES  = 400;   // long receiver hold-off to fill the block
  localparam int SETTLE       = 12;    // cycles to let groupless bytes flow through
  localparam int PHASE_WORDS  = 96;    // random byte words per configuration phase
  localparam int DIR_ROWS     = 26;

  localparam logic [15:0] PEC_POLY = 16'h4599;
  localparam logic [15:0] PEC_SEED = 16'd16;
  localparam logic [2:0]  SWEEP_LEN_ADDR = {REG_GROUPS_PER_SWEEP, 2'b00};

  // Sweep lengths of the random phases, walked from index 0; 0 and 7 lie outside 1..4
  localparam logic [7:0][2:0] SWEEP_PLAN =
    {3'd4, 3'd2, 3'd7, 3'd0, 3'd3, 3'd4, 3'd1, 3'd1};

  typedef enum logic [1:0] {
    ROW_DATA, ROW_PEC_HIGH, ROW_PEC_LOW_GOOD, ROW_PEC_LOW_BAD
  } row_kind_t;

  typedef struct packed {
    row_kind_t  kind;
    logic [7:0] value;    // only used for data rows
    logic       restart;
    logic       typed;    // the group result of this row is written out by hand
  } dir_row_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  item_t       item    = '0;
  logic        push    = 1'b0;
  logic        full;
  result_t     result;
  logic        empty;
  logic        pop     = 1'b0;
  logic        psel    = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite  = 1'b0;
  logic [2:0]  paddr   = '0;
  logic [31:0] pwdata  = '0;
  logic [31:0] prdata;
  logic        pready;

  cell_group_pec_checker_top u_top (
    .clk     (clk),
    .rst     (rst),
    .item    (item),
    .push    (push),
    .full    (full),
    .result  (result),
    .empty   (empty),
    .pop     (pop),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // Group predictor: its own copy of the checker's state and sweep length
  // ---------------------------------------------------------------------------
  logic [2:0]  pos_seen      = 3'd0;
  logic [15:0] crc_run       = PEC_SEED;
  logic [7:0]  cell_bytes [6];
  logic [7:0]  pec_high_seen = 8'h00;
  logic [1:0]  group_idx     = 2'd0;
  logic        sweep_bad     = 1'b0;
  logic [2:0]  sweep_len     = GROUPS_RESET;

  result_t expected_groups [$];

  int words_in        = 0;
  int results_checked = 0;
  int mismatches      = 0;
  int pec_fails_seen  = 0;
  int sweeps_closed   = 0;
  int cfg_writes      = 0;
  int cycle_count     = 0;

  function automatic logic [15:0] crc15_entry(input logic [7:0] idx);
    logic [15:0] acc;
    acc = 16'(idx) << 7;
    repeat (8) begin
      if (acc[14]) begin
        acc = (acc << 1) ^ PEC_POLY;
      end else begin
        acc = acc << 1;
      end
    end
    return acc;
  endfunction

  function automatic logic [15:0] crc15_step(input logic [15:0] crc, input logic [7:0] v);
    logic [7:0] addr;
    addr = 8'(crc >> 7) ^ v;
    return (crc << 8) ^ crc15_entry(addr);
  endfunction

  // Out-of-range lengths clamp: 0 acts as one group, anything above the maximum as the maximum
  function automatic int sweep_groups();
    if (sweep_len == 3'd0) begin
      return 1;
    end else if (int'(sweep_len) > MAX_GROUPS) begin
      return MAX_GROUPS;
    end
    return int'(sweep_len);
  endfunction

  // The PEC the block will accept for the bytes taken so far
  function automatic logic [15:0] pec_now();
    return {crc_run[14:0], 1'b0};
  endfunction

  task automatic pec_group_step(input item_t w, output logic made, output result_t r);
    logic [15:0] received;
    logic        ok;
    logic        last;
    made = 1'b0;
    r    = '0;
    if (w.restart) begin
      pos_seen  = 3'd0;
      crc_run   = PEC_SEED;
      group_idx = 2'd0;
      sweep_bad = 1'b0;
    end
    if (pos_seen < 3'd6) begin
      cell_bytes[pos_seen] = w.rx_byte;
      crc_run  = crc15_step(crc_run, w.rx_byte);
      pos_seen = pos_seen + 3'd1;
    end else if (pos_seen == 3'd6) begin
      pec_high_seen = w.rx_byte;
      pos_seen      = 3'd7;
    end else begin
      // eighth byte closes the group
      received = {pec_high_seen, w.rx_byte};
      ok       = (received == pec_now());
      if (!ok) begin
        sweep_bad = 1'b1;
      end
      last = (int'(group_idx) + 1 >= sweep_groups());
      r.group_number     = group_idx;
      r.cell_code_first  = {cell_bytes[1], cell_bytes[0]};
      r.cell_code_second = {cell_bytes[3], cell_bytes[2]};
      r.cell_code_third  = {cell_bytes[5], cell_bytes[4]};
      r.pec_ok           = ok;
      r.sweep_failed     = sweep_bad;
      r.last_group       = last;
      made     = 1'b1;
      pos_seen = 3'd0;
      crc_run  = PEC_SEED;
      if (last) begin
        group_idx = 2'd0;
        sweep_bad = 1'b0;
      end else begin
        group_idx = group_idx + 2'd1;
      end
    end
  endtask

  // ---------------------------------------------------------------------------
  // Checking
  // ---------------------------------------------------------------------------
  task automatic flag_mismatch(input string msg);
    mismatches++;
    if (mismatches <= 10) begin
      $display("[%0t] mismatch: %s", $realtime, msg);
    end
  endtask

  function automatic string describe(input result_t r);
    return $sformatf("grp=%0d cells=%h/%h/%h ok=%0d failed=%0d last=%0d",
                     r.group_number, r.cell_code_first, r.cell_code_second,
                     r.cell_code_third, r.pec_ok, r.sweep_failed, r.last_group);
  endfunction

  task automatic check_group(input result_t got);
    result_t want;
    string   diff;
    diff = "";
    if (expected_groups.size() == 0) begin
      flag_mismatch({"group word with nothing expected: ", describe(got)});
    end else begin
      want = expected_groups.pop_front();
      if (got.group_number !== want.group_number) diff = {diff, " group_number"};
      if (got.cell_code_first !== want.cell_code_first) diff = {diff, " cell_code_first"};
      if (got.cell_code_second !== want.cell_code_second) diff = {diff, " cell_code_second"};
      if (got.cell_code_third !== want.cell_code_third) diff = {diff, " cell_code_third"};
      if (got.pec_ok !== want.pec_ok) diff = {diff, " pec_ok"};
      if (got.sweep_failed !== want.sweep_failed) diff = {diff, " sweep_failed"};
      if (got.last_group !== want.last_group) diff = {diff, " last_group"};
      if (diff != "") begin
        flag_mismatch({"fields", diff, "\n  expected ", describe(want),
                       "\n  actual   ", describe(got)});
      end
    end
    results_checked++;
    if (got.pec_ok === 1'b0) pec_fails_seen++;
    if (got.last_group === 1'b1) sweeps_closed++;
  endtask

  // ---------------------------------------------------------------------------
  // Byte side
  // ---------------------------------------------------------------------------
  // Idle about a third of the time, except for one calm stretch of words
  function automatic logic sender_idles();
    if (words_in >= 300 && words_in < 420) return 1'b0;
    return ($urandom_range(99) < 32);
  endfunction

  // Offer one byte word and hold it until taken; log the expected group word, if any.
  // A typed expectation replaces the predicted one for hand-written rows.
  task automatic send_word(input logic [7:0] b, input logic rs,
                           input logic use_typed, input result_t typed);
    item_t   w;
    logic    made;
    result_t predicted;
    w = {b, rs};
    while (sender_idles()) begin
      push <= 1'b0;
      @(posedge clk);
    end
    item <= w;
    push <= 1'b1;
    @(posedge clk);
    while (full) @(posedge clk);
    words_in++;
    pec_group_step(w, made, predicted);
    if (made) begin
      expected_groups.push_back(use_typed ? typed : predicted);
    end
  endtask

  function automatic logic [7:0] data_byte();
    case ($urandom_range(7))
      0:       return 8'h00;
      1:       return 8'hFF;
      default: return 8'($urandom_range(255));
    endcase
  endfunction

  // Six data bytes and a PEC, good or with one bit flipped
  task automatic send_group(input logic rs_first, input logic good);
    logic [15:0] pec;
    for (int i = 0; i < 6; i++) begin
      send_word(data_byte(), rs_first && i == 0, 1'b0, '0);
    end
    pec = pec_now();
    if (!good) pec = pec ^ (16'd1 << $urandom_range(15));
    send_word(pec[15:8], 1'b0, 1'b0, '0);
    send_word(pec[7:0], 1'b0, 1'b0, '0);
  endtask

  // Drop push, wait for every group word, then let trailing bytes settle
  task automatic drain_to_idle();
    push <= 1'b0;
    while (expected_groups.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  // ---------------------------------------------------------------------------
  // Configuration port
  // ---------------------------------------------------------------------------
  task automatic apb_cycle(input logic wr, input logic [31:0] wdata,
                           output logic [31:0] rdata);
    @(posedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= wr;
    paddr   <= SWEEP_LEN_ADDR;
    pwdata  <= wdata;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    rdata = prdata;
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  task automatic check_sweep_len();
    logic [31:0] rd;
    apb_cycle(1'b0, 32'd0, rd);
    if (rd[2:0] !== sweep_len) begin
      flag_mismatch($sformatf("groups_per_sweep read back %0d, expected %0d",
                              rd[2:0], sweep_len));
    end
  endtask

  task automatic set_sweep_len(input logic [2:0] v);
    logic [31:0] rd;
    apb_cycle(1'b1, 32'(v), rd);
    sweep_len = v;
    cfg_writes++;
    check_sweep_len();
  endtask

  // ---------------------------------------------------------------------------
  // Result side: random stalls, one calm stretch, one long hold-off
  // ---------------------------------------------------------------------------
  function automatic logic receiver_stalls();
    if (results_checked >= 50 && results_checked < 75) return 1'b0;
    return ($urandom_range(99) < 32);
  endfunction

  initial begin
    int  hold_left;
    logic hold_done;
    hold_left = 0;
    hold_done = 1'b0;
    while (rst) @(posedge clk);
    forever begin
      @(posedge clk);
      if (pop && !empty) check_group(result);
      if (hold_left > 0) begin
        hold_left--;
        pop <= 1'b0;
      end else if (!hold_done && results_checked >= 25) begin
        // hold off long enough for the byte side to back up and raise full
        hold_done = 1'b1;
        hold_left = HOLD_CYCLES - 1;
        pop <= 1'b0;
      end else begin
        pop <= !receiver_stalls();
      end
    end
  end

  // Watchdog
  initial begin
    while (cycle_count < LIMIT_CYCLES) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("== FAIL ==");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Stimulus
  // ---------------------------------------------------------------------------
  initial begin
    dir_row_t    dir_rows [DIR_ROWS];
    result_t     typed_groups [3];
    dir_row_t    row;
    result_t     typed_pick;
    logic [7:0]  b;
    logic [15:0] pec;
    logic        need_restart;
    logic        first_rs;
    int          typed_idx;
    int          phase_end;
    int          roll;
    int          n;

    // Directed table, sweep length 2.  Two stray bytes, then a restart in mid-group
    // that opens group 0 of all-zero cells with a broken PEC; group 1 of all-ones
    // cells closes the sweep with the error still sticky; the next group opens a
    // clean sweep without any restart.
    dir_rows[0]  = {ROW_DATA,         8'h5A, 1'b1, 1'b0};
    dir_rows[1]  = {ROW_DATA,         8'hA5, 1'b0, 1'b0};
    dir_rows[2]  = {ROW_DATA,         8'h00, 1'b1, 1'b0};
    dir_rows[3]  = {ROW_DATA,         8'h00, 1'b0, 1'b0};
    dir_rows[4]  = {ROW_DATA,         8'h00, 1'b0, 1'b0};
    dir_rows[5]  = {ROW_DATA,         8'h00, 1'b0, 1'b0};
    dir_rows[6]  = {ROW_DATA,         8'h00, 1'b0, 1'b0};
    dir_rows[7]  = {ROW_DATA,         8'h00, 1'b0, 1'b0};
    dir_rows[8]  = {ROW_PEC_HIGH,     8'h00, 1'b0, 1'b0};
    dir_rows[9]  = {ROW_PEC_LOW_BAD,  8'h00, 1'b0, 1'b1};
    dir_rows[10] = {ROW_DATA,         8'hFF, 1'b0, 1'b0};
    dir_rows[11] = {ROW_DATA,         8'hFF, 1'b0, 1'b0};
    dir_rows[12] = {ROW_DATA,         8'hFF, 1'b0, 1'b0};
    dir_rows[13] = {ROW_DATA,         8'hFF, 1'b0, 1'b0};
    dir_rows[14] = {ROW_DATA,         8'hFF, 1'b0, 1'b0};
    dir_rows[15] = {ROW_DATA,         8'hFF, 1'b0, 1'b0};
    dir_rows[16] = {ROW_PEC_HIGH,     8'h00, 1'b0, 1'b0};
    dir_rows[17] = {ROW_PEC_LOW_GOOD, 8'h00, 1'b0, 1'b1};
    dir_rows[18] = {ROW_DATA,         8'h01, 1'b0, 1'b0};
    dir_rows[19] = {ROW_DATA,         8'h80, 1'b0, 1'b0};
    dir_rows[20] = {ROW_DATA,         8'h7E, 1'b0, 1'b0};
    dir_rows[21] = {ROW_DATA,         8'h00, 1'b0, 1'b0};
    dir_rows[22] = {ROW_DATA,         8'hFF, 1'b0, 1'b0};
    dir_rows[23] = {ROW_DATA,         8'h10, 1'b0, 1'b0};
    dir_rows[24] = {ROW_PEC_HIGH,     8'h00, 1'b0, 1'b0};
    dir_rows[25] = {ROW_PEC_LOW_GOOD, 8'h00, 1'b0, 1'b1};

    //                  group  first     second    third     ok    failed last
    typed_groups[0] = {2'd0, 16'h0000, 16'h0000, 16'h0000, 1'b0, 1'b1, 1'b0};
    typed_groups[1] = {2'd1, 16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b1, 1'b1, 1'b1};
    typed_groups[2] = {2'd0, 16'h8001, 16'h007E, 16'h10FF, 1'b1, 1'b0, 1'b0};

    typed_idx    = 0;
    need_restart = 1'b1;

    repeat (6) @(posedge clk);
    rst <= 1'b0;

    // reset value first, then the directed sweep length
    check_sweep_len();
    set_sweep_len(3'd2);

    for (int i = 0; i < DIR_ROWS; i++) begin
      row        = dir_rows[i];
      pec        = pec_now();
      typed_pick = '0;
      case (row.kind)
        ROW_PEC_HIGH:     b = pec[15:8];
        ROW_PEC_LOW_GOOD: b = pec[7:0];
        ROW_PEC_LOW_BAD:  b = pec[7:0] ^ 8'h01;
        default:          b = row.value;
      endcase
      if (row.typed) begin
        typed_pick = typed_groups[typed_idx];
        typed_idx++;
      end
      send_word(b, row.restart, row.typed, typed_pick);
    end

    // Random phases: mostly whole sweeps, some cut-off groups and loose bytes
    for (int phase = 0; phase < 8; phase++) begin
      drain_to_idle();
      set_sweep_len(SWEEP_PLAN[phase]);
      phase_end = words_in + PHASE_WORDS;
      while (words_in < phase_end) begin
        roll = $urandom_range(99);
        if (roll < 78) begin
          // sweeps usually open with a restart; otherwise rely on the self-clear
          first_rs = need_restart || ($urandom_range(3) != 0);
          for (int g = 0; g < sweep_groups(); g++) begin
            send_group(first_rs && g == 0, $urandom_range(99) < 80);
          end
          need_restart = 1'b0;
        end else if (roll < 90) begin
          // group cut short; the next sweep restarts to realign
          n = $urandom_range(1, 7);
          for (int k = 0; k < n; k++) begin
            send_word(data_byte(), k == 0 && $urandom_range(1) == 1, 1'b0, '0);
          end
          need_restart = 1'b1;
        end else begin
          // loose bytes with stray restarts landing at any position
          n = $urandom_range(1, 9);
          for (int k = 0; k < n; k++) begin
            send_word(8'($urandom_range(255)), $urandom_range(9) == 0, 1'b0, '0);
          end
          need_restart = 1'b1;
        end
      end
    end

    drain_to_idle();

    if (expected_groups.size() != 0) begin
      flag_mismatch($sformatf("%0d group words never arrived", expected_groups.size()));
    end

    $display("Run covered %0d byte words and %0d group words (%0d PEC failures, %0d sweeps).",
             words_in, results_checked, pec_fails_seen, sweeps_closed);
    $display("Sweep length written %0d times incl. 0 and 7; %0d mismatches in %0d cycles.",
             cfg_writes, mismatches, cycle_count);
    if (mismatches == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
